### hw/rtl/tfr_pkg.sv
// Shared types, codes and expansion helpers for the texel format decoder.
// Used by tfr_cfg_regs, tfr_issue, tfr_expand and texel_format_to_rgba8888.
package tfr_pkg;

  typedef enum logic [3:0] {
    FMT_RGBA16 = 4'd0,
    FMT_RGBA32 = 4'd1,
    FMT_IA4    = 4'd2,
    FMT_IA8    = 4'd3,
    FMT_IA16   = 4'd4,
    FMT_I4     = 4'd5,
    FMT_I8     = 4'd6,
    FMT_CI4    = 4'd7,
    FMT_CI8    = 4'd8,
    FMT_YUV    = 4'd9
  } texel_fmt_e;

  typedef enum logic [3:0] {
    REG_TEXEL_FORMAT   = 4'd0,
    REG_PALETTE_FORMAT = 4'd1,
    REG_FORCE_OPAQUE   = 4'd2,
    REG_LUMA_GAIN      = 4'd3,
    REG_V_TO_RED       = 4'd4,
    REG_U_TO_GREEN     = 4'd5,
    REG_V_TO_GREEN     = 4'd6,
    REG_U_TO_BLUE      = 4'd7
  } cfg_reg_e;

  typedef enum logic {
    CMD_CONVERT   = 1'b0,
    CMD_PAL_WRITE = 1'b1
  } cmd_e;

  typedef enum logic {
    PAL_RGBA5551 = 1'b0,
    PAL_IA16     = 1'b1
  } pal_fmt_e;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned CoefW    = 10;
  localparam int unsigned ProdW    = 21;
  localparam int unsigned SumW     = 23;

  localparam logic [CoefW-1:0] LumaGainRst = 10'd298;
  localparam logic [CoefW-1:0] VToRedRst   = 10'd409;
  localparam logic [CoefW-1:0] UToGreenRst = 10'd100;
  localparam logic [CoefW-1:0] VToGreenRst = 10'd208;
  localparam logic [CoefW-1:0] UToBlueRst  = 10'd516;

  typedef struct packed {
    logic [3:0]       texel_format;
    logic             palette_format;
    logic             force_opaque;
    logic [CoefW-1:0] luma_gain;
    logic [CoefW-1:0] v_to_red;
    logic [CoefW-1:0] u_to_green;
    logic [CoefW-1:0] v_to_green;
    logic [CoefW-1:0] u_to_blue;
  } cfg_t;

  // one texel slot on its way to the expansion stage
  typedef struct packed {
    logic [3:0]  fmt;
    logic [31:0] data;
    logic        second;
    logic        last;
  } slot_t;

  typedef struct packed {
    logic signed [ProdW-1:0] ly;
    logic signed [ProdW-1:0] vr;
    logic signed [ProdW-1:0] ug;
    logic signed [ProdW-1:0] vg;
    logic signed [ProdW-1:0] ub;
  } yuv_prod_t;

  function automatic logic fmt_valid(input logic [3:0] f);
    return f <= FMT_YUV;
  endfunction

  function automatic logic fmt_paired(input logic [3:0] f);
    return (f == FMT_IA4) || (f == FMT_I4) || (f == FMT_CI4) || (f == FMT_YUV);
  endfunction

  function automatic logic [7:0] exp5(input logic [4:0] x);
    return {x, x[4:2]};
  endfunction

  function automatic logic [7:0] exp4(input logic [3:0] x);
    return {x, x};
  endfunction

  function automatic logic [7:0] exp3(input logic [2:0] x);
    return {x, x, x[2:1]};
  endfunction

  function automatic logic [7:0] yuv_clamp(input logic signed [SumW-1:0] s);
    logic [7:0] r;
    if (s[SumW-1]) begin
      r = 8'd0;
    end else if (|s[SumW-2:16]) begin
      r = 8'hFF;
    end else begin
      r = s[15:8];
    end
    return r;
  endfunction

endpackage

### hw/rtl/tfr_cfg_regs.sv
// Configuration register file for the texel format decoder.
// Depends on tfr_pkg for the register codes, reset values and cfg_t.
module tfr_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tfr_pkg::CfgDataW-1:0] cfg_data_i,
  output tfr_pkg::cfg_t                cfg_o
);

  tfr_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tfr_pkg::REG_TEXEL_FORMAT:   cfg_d.texel_format   = cfg_data_i[3:0];
        tfr_pkg::REG_PALETTE_FORMAT: cfg_d.palette_format = cfg_data_i[0];
        tfr_pkg::REG_FORCE_OPAQUE:   cfg_d.force_opaque   = cfg_data_i[0];
        tfr_pkg::REG_LUMA_GAIN:      cfg_d.luma_gain      = cfg_data_i;
        tfr_pkg::REG_V_TO_RED:       cfg_d.v_to_red       = cfg_data_i;
        tfr_pkg::REG_U_TO_GREEN:     cfg_d.u_to_green     = cfg_data_i;
        tfr_pkg::REG_V_TO_GREEN:     cfg_d.v_to_green     = cfg_data_i;
        tfr_pkg::REG_U_TO_BLUE:      cfg_d.u_to_blue      = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.texel_format   <= tfr_pkg::FMT_RGBA16;
      cfg_q.palette_format <= tfr_pkg::PAL_RGBA5551;
      cfg_q.force_opaque   <= 1'b0;
      cfg_q.luma_gain      <= tfr_pkg::LumaGainRst;
      cfg_q.v_to_red       <= tfr_pkg::VToRedRst;
      cfg_q.u_to_green     <= tfr_pkg::UToGreenRst;
      cfg_q.v_to_green     <= tfr_pkg::VToGreenRst;
      cfg_q.u_to_blue      <= tfr_pkg::UToBlueRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hw/rtl/tfr_issue.sv
// Input register, texel slot sequencer, palette memory and YUV products.
// Depends on tfr_pkg; feeds tfr_expand one texel slot per cycle while en_i is high.
module tfr_issue #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic                   command_i,
  input  logic [31:0]            data_i,
  input  logic [7:0]             palette_index_i,
  input  logic                   en_i,
  input  tfr_pkg::cfg_t          cfg_i,
  output logic                   b_valid_o,
  output tfr_pkg::slot_t         b_slot_o,
  output tfr_pkg::yuv_prod_t     b_prod_o,
  output logic [15:0]            b_pal_o,
  output logic                   b_pal_oob_o
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  logic                 a_valid_q, a_valid_d;
  logic                 phase_q, phase_d;
  logic                 a_cmd_q;
  logic [31:0]          a_data_q;
  logic [7:0]           a_idx_q;

  logic                 b_valid_q;
  tfr_pkg::slot_t       b_slot_q;
  tfr_pkg::yuv_prod_t   b_prod_q;
  logic [15:0]          pal_rd_q;
  logic                 pal_oob_q;

  logic [15:0]          pal_mem [PALETTE_DEPTH];

  logic                 convert, paired, a_done, issue, accept;
  logic                 pal_we;
  logic [7:0]           rd_idx;
  logic                 rd_oob;
  logic [3:0]           nib;
  logic [7:0]           y8;
  logic signed [10:0]   c_ly, c_vr, c_ug, c_vg, c_ub;
  logic signed [9:0]    ys, us, vs;
  tfr_pkg::slot_t       slot;
  tfr_pkg::yuv_prod_t   prod;

  assign convert = (a_cmd_q == tfr_pkg::CMD_CONVERT);
  assign paired  = convert && tfr_pkg::fmt_paired(cfg_i.texel_format);
  assign a_done  = !paired || phase_q;
  assign issue   = a_valid_q && en_i;

  assign in_stall_o = a_valid_q && !(en_i && a_done);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    a_valid_d = a_valid_q;
    phase_d   = phase_q;
    if (accept) begin
      a_valid_d = 1'b1;
      phase_d   = 1'b0;
    end else if (issue) begin
      a_valid_d = !a_done;
      phase_d   = !a_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      phase_q   <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      phase_q   <= phase_d;
      if (en_i) begin
        b_valid_q <= issue && convert && tfr_pkg::fmt_valid(cfg_i.texel_format);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_cmd_q  <= command_i;
      a_data_q <= data_i;
      a_idx_q  <= palette_index_i;
    end
  end

  // palette lookup address: the texel index with its low bit flipped
  assign nib    = phase_q ? a_data_q[3:0] : a_data_q[7:4];
  assign rd_idx = ((cfg_i.texel_format == tfr_pkg::FMT_CI4) ? {4'd0, nib} : a_data_q[7:0])
                  ^ 8'h01;
  assign rd_oob = 32'(rd_idx) >= PALETTE_DEPTH;
  assign pal_we = issue && (a_cmd_q == tfr_pkg::CMD_PAL_WRITE)
                  && (32'(a_idx_q) < PALETTE_DEPTH);

  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[a_idx_q[AW-1:0]] <= a_data_q[15:0];
    end
    if (en_i) begin
      pal_rd_q  <= pal_mem[rd_idx[AW-1:0]];
      pal_oob_q <= rd_oob;
    end
  end

  // YUV products, one per coefficient
  assign y8   = phase_q ? a_data_q[7:0] : a_data_q[23:16];
  assign ys   = $signed({2'b00, y8}) - 10'sd16;
  assign us   = $signed({2'b00, a_data_q[31:24]}) - 10'sd128;
  assign vs   = $signed({2'b00, a_data_q[15:8]}) - 10'sd128;
  assign c_ly = $signed({1'b0, cfg_i.luma_gain});
  assign c_vr = $signed({1'b0, cfg_i.v_to_red});
  assign c_ug = $signed({1'b0, cfg_i.u_to_green});
  assign c_vg = $signed({1'b0, cfg_i.v_to_green});
  assign c_ub = $signed({1'b0, cfg_i.u_to_blue});

  always_comb begin
    prod.ly = tfr_pkg::ProdW'(c_ly) * tfr_pkg::ProdW'(ys);
    prod.vr = tfr_pkg::ProdW'(c_vr) * tfr_pkg::ProdW'(vs);
    prod.ug = tfr_pkg::ProdW'(c_ug) * tfr_pkg::ProdW'(us);
    prod.vg = tfr_pkg::ProdW'(c_vg) * tfr_pkg::ProdW'(vs);
    prod.ub = tfr_pkg::ProdW'(c_ub) * tfr_pkg::ProdW'(us);
    slot.fmt    = cfg_i.texel_format;
    slot.data   = a_data_q;
    slot.second = phase_q;
    slot.last   = a_done;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b_slot_q <= slot;
      b_prod_q <= prod;
    end
  end

  assign b_valid_o   = b_valid_q;
  assign b_slot_o    = b_slot_q;
  assign b_prod_o    = b_prod_q;
  assign b_pal_o     = pal_rd_q;
  assign b_pal_oob_o = pal_oob_q;

  a_phase_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> a_valid_q)
    else $error("second texel phase without a held item");

  a_pair_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_valid_q && paired && !phase_q) |-> in_stall_o)
    else $error("input taken before the second texel was issued");

  a_pair_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_valid_q && !b_slot_q.last && en_i) |=> (b_valid_q && b_slot_q.second))
    else $error("first texel of a pair not followed by the second");

endmodule

### hw/rtl/tfr_expand.sv
// Texel expansion to RGBA8888 and the result register.
// Depends on tfr_pkg; takes texel slots from tfr_issue.
module tfr_expand (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tfr_pkg::cfg_t      cfg_i,
  input  logic               b_valid_i,
  input  tfr_pkg::slot_t     b_slot_i,
  input  tfr_pkg::yuv_prod_t b_prod_i,
  input  logic [15:0]        b_pal_i,
  input  logic               b_pal_oob_i,
  output logic               en_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [7:0]         alpha_o,
  output logic               last_o
);

  logic                          c_valid_q;
  logic [7:0]                    red_q, green_q, blue_q, alpha_q;
  logic                          last_q;
  logic [7:0]                    red_d, green_d, blue_d, alpha_d;
  logic [3:0]                    nib;
  logic [7:0]                    lo8, ival;
  logic [15:0]                   w16, pw;
  logic signed [tfr_pkg::SumW-1:0] sr, sg, sb;

  assign en_o = !c_valid_q || !out_stall_i;

  assign lo8 = b_slot_i.data[7:0];
  assign w16 = b_slot_i.data[15:0];
  assign nib = b_slot_i.second ? lo8[3:0] : lo8[7:4];
  assign pw  = b_pal_oob_i ? 16'h0000 : b_pal_i;

  assign sr = tfr_pkg::SumW'(b_prod_i.ly) + tfr_pkg::SumW'(b_prod_i.vr);
  assign sg = tfr_pkg::SumW'(b_prod_i.ly) + tfr_pkg::SumW'(b_prod_i.ug)
            - tfr_pkg::SumW'(b_prod_i.vg);
  assign sb = tfr_pkg::SumW'(b_prod_i.ly) + tfr_pkg::SumW'(b_prod_i.ub);

  always_comb begin
    red_d   = 8'd0;
    green_d = 8'd0;
    blue_d  = 8'd0;
    alpha_d = 8'd0;
    ival    = 8'd0;
    unique case (b_slot_i.fmt)
      tfr_pkg::FMT_RGBA16: begin
        red_d   = tfr_pkg::exp5(w16[15:11]);
        green_d = tfr_pkg::exp5(w16[10:6]);
        blue_d  = tfr_pkg::exp5(w16[5:1]);
        alpha_d = {8{w16[0]}};
      end
      tfr_pkg::FMT_RGBA32: begin
        red_d   = b_slot_i.data[31:24];
        green_d = b_slot_i.data[23:16];
        blue_d  = b_slot_i.data[15:8];
        alpha_d = b_slot_i.data[7:0];
      end
      tfr_pkg::FMT_IA4: begin
        ival    = tfr_pkg::exp3(nib[3:1]);
        red_d   = ival;
        green_d = ival;
        blue_d  = ival;
        alpha_d = {8{nib[0]}};
      end
      tfr_pkg::FMT_IA8: begin
        ival    = tfr_pkg::exp4(lo8[7:4]);
        red_d   = ival;
        green_d = ival;
        blue_d  = ival;
        alpha_d = tfr_pkg::exp4(lo8[3:0]);
      end
      tfr_pkg::FMT_IA16: begin
        red_d   = w16[15:8];
        green_d = w16[15:8];
        blue_d  = w16[15:8];
        alpha_d = w16[7:0];
      end
      tfr_pkg::FMT_I4: begin
        ival    = tfr_pkg::exp4(nib);
        red_d   = ival;
        green_d = ival;
        blue_d  = ival;
        alpha_d = ival;
      end
      tfr_pkg::FMT_I8: begin
        red_d   = lo8;
        green_d = lo8;
        blue_d  = lo8;
        alpha_d = lo8;
      end
      tfr_pkg::FMT_CI4, tfr_pkg::FMT_CI8: begin
        if (cfg_i.palette_format == tfr_pkg::PAL_IA16) begin
          red_d   = pw[15:8];
          green_d = pw[15:8];
          blue_d  = pw[15:8];
          alpha_d = pw[7:0];
        end else begin
          red_d   = tfr_pkg::exp5(pw[15:11]);
          green_d = tfr_pkg::exp5(pw[10:6]);
          blue_d  = tfr_pkg::exp5(pw[5:1]);
          alpha_d = {8{pw[0]}};
        end
        if (cfg_i.force_opaque) begin
          alpha_d = 8'hFF;
        end
      end
      tfr_pkg::FMT_YUV: begin
        red_d   = tfr_pkg::yuv_clamp(sr);
        green_d = tfr_pkg::yuv_clamp(sg);
        blue_d  = tfr_pkg::yuv_clamp(sb);
        alpha_d = 8'hFF;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (en_o) begin
      c_valid_q <= b_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && b_valid_i) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      alpha_q <= alpha_d;
      last_q  <= b_slot_i.last;
    end
  end

  assign out_valid_o = c_valid_q;
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;
  assign alpha_o     = alpha_q;
  assign last_o      = last_q;

endmodule

### hw/rtl/texel_format_to_rgba8888.sv
// Texel decoder top level: expands fetched texel words to RGBA8888.
// Depends on tfr_pkg, tfr_cfg_regs, tfr_issue and tfr_expand.
//
// An item is either a texel word to convert or a palette entry write. One texel
// leaves the block per cycle while out_stall_i is low: rgba16, rgba32, ia8, ia16,
// i8 and ci8 items give one texel each, while ia4, i4, ci4 and yuv items give two
// texels, the second marked last. A palette write gives no result. The input
// register hands the item to the expansion stage one texel slot at a time; the
// palette memory has one read port, so each slot does a single lookup. A result
// passes the input register, the slot register and the result register.
// The palette memory is not cleared; only written entries may be looked up.
module texel_format_to_rgba8888 #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [31:0]                  data_i,
  input  logic [7:0]                   palette_index_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   red_o,
  output logic [7:0]                   green_o,
  output logic [7:0]                   blue_o,
  output logic [7:0]                   alpha_o,
  output logic                         last_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tfr_pkg::CfgDataW-1:0] cfg_data_i
);

  tfr_pkg::cfg_t      cfg;
  logic               en;
  logic               b_valid;
  tfr_pkg::slot_t     b_slot;
  tfr_pkg::yuv_prod_t b_prod;
  logic [15:0]        b_pal;
  logic               b_pal_oob;

  tfr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  tfr_issue #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_issue (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .data_i          (data_i),
    .palette_index_i (palette_index_i),
    .en_i            (en),
    .cfg_i           (cfg),
    .b_valid_o       (b_valid),
    .b_slot_o        (b_slot),
    .b_prod_o        (b_prod),
    .b_pal_o         (b_pal),
    .b_pal_oob_o     (b_pal_oob)
  );

  tfr_expand u_expand (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .b_valid_i   (b_valid),
    .b_slot_i    (b_slot),
    .b_prod_i    (b_prod),
    .b_pal_i     (b_pal),
    .b_pal_oob_i (b_pal_oob),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .alpha_o     (alpha_o),
    .last_o      (last_o)
  );

endmodule

### tb/texel_checker.sv
`timescale 1ns / 100ps
// Checker for texel_format_to_rgba8888: watches the input, output and register
// channels, predicts each texel and compares results in order. Depends on tfr_pkg.
module texel_checker #(
  parameter int unsigned PAL_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_i,
  input  logic                         command_i,
  input  logic [31:0]                  data_i,
  input  logic [7:0]                   palette_index_i,
  input  logic                         out_valid_i,
  input  logic                         out_stall_i,
  input  logic [7:0]                   red_i,
  input  logic [7:0]                   green_i,
  input  logic [7:0]                   blue_i,
  input  logic [7:0]                   alpha_i,
  input  logic                         last_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [tfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tfr_pkg::CfgDataW-1:0] cfg_data_i,
  output int unsigned                  mismatch_count_o,
  output int unsigned                  texels_checked_o,
  output int unsigned                  texels_waiting_o
);
  import tfr_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } rgba_texel_t;

  cfg_t        settings;
  logic [15:0] palette_mem [PAL_DEPTH];
  rgba_texel_t texel_expect_q [$];

  assign texels_waiting_o = texel_expect_q.size();

  function automatic logic [7:0] widen5(logic [4:0] x);
    return (8'(x) << 3) | (8'(x) >> 2);
  endfunction

  function automatic logic [7:0] widen4(logic [3:0] x);
    return 8'(x) * 8'd17;
  endfunction

  function automatic logic [7:0] widen3(logic [2:0] x);
    return (8'(x) << 5) | (8'(x) << 2) | (8'(x) >> 1);
  endfunction

  function automatic void push_texel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [7:0] a, logic last);
    rgba_texel_t t;
    t.red   = r;
    t.green = g;
    t.blue  = b;
    t.alpha = a;
    t.last  = last;
    texel_expect_q.push_back(t);
  endfunction

  // lookup is at index xor 1
  function automatic void push_palette(logic [7:0] idx, logic last);
    int unsigned slot;
    logic [15:0] w;
    logic [7:0]  a;
    slot = int'(idx ^ 8'h01);
    w = (slot < PAL_DEPTH) ? palette_mem[slot] : 16'h0000;
    if (settings.palette_format == PAL_IA16) begin
      a = settings.force_opaque ? 8'hFF : w[7:0];
      push_texel(w[15:8], w[15:8], w[15:8], a, last);
    end else begin
      a = settings.force_opaque ? 8'hFF : {8{w[0]}};
      push_texel(widen5(w[15:11]), widen5(w[10:6]), widen5(w[5:1]), a, last);
    end
  endfunction

  function automatic logic [7:0] yuv_level(int s);
    if (s < 0) return 8'h00;
    if ((s >>> 8) > 255) return 8'hFF;
    return 8'(s >>> 8);
  endfunction

  function automatic void push_yuv(logic [7:0] y, logic [7:0] u, logic [7:0] v,
                                   logic last);
    int luma;
    int cu;
    int cv;
    luma = int'(settings.luma_gain) * (int'(y) - 16);
    cu   = int'(u) - 128;
    cv   = int'(v) - 128;
    push_texel(yuv_level(luma + int'(settings.v_to_red) * cv),
               yuv_level(luma + int'(settings.u_to_green) * cu
                              - int'(settings.v_to_green) * cv),
               yuv_level(luma + int'(settings.u_to_blue) * cu),
               8'hFF, last);
  endfunction

  function automatic void predict_item(logic cmd, logic [31:0] d, logic [7:0] pidx);
    logic [7:0] lo;
    logic [7:0] lvl;
    lo = d[7:0];
    if (cmd == CMD_PAL_WRITE) begin
      if (pidx < PAL_DEPTH) palette_mem[pidx] = d[15:0];
      return;
    end
    case (settings.texel_format)
      FMT_RGBA16: push_texel(widen5(d[15:11]), widen5(d[10:6]), widen5(d[5:1]),
                             {8{d[0]}}, 1'b1);
      FMT_RGBA32: push_texel(d[31:24], d[23:16], d[15:8], d[7:0], 1'b1);
      FMT_IA4: begin
        lvl = widen3(lo[7:5]);
        push_texel(lvl, lvl, lvl, {8{lo[4]}}, 1'b0);
        lvl = widen3(lo[3:1]);
        push_texel(lvl, lvl, lvl, {8{lo[0]}}, 1'b1);
      end
      FMT_IA8: begin
        lvl = widen4(lo[7:4]);
        push_texel(lvl, lvl, lvl, widen4(lo[3:0]), 1'b1);
      end
      FMT_IA16:   push_texel(d[15:8], d[15:8], d[15:8], d[7:0], 1'b1);
      FMT_I4: begin
        lvl = widen4(lo[7:4]);
        push_texel(lvl, lvl, lvl, lvl, 1'b0);
        lvl = widen4(lo[3:0]);
        push_texel(lvl, lvl, lvl, lvl, 1'b1);
      end
      FMT_I8:     push_texel(lo, lo, lo, lo, 1'b1);
      FMT_CI4: begin
        push_palette({4'h0, lo[7:4]}, 1'b0);
        push_palette({4'h0, lo[3:0]}, 1'b1);
      end
      FMT_CI8:    push_palette(lo, 1'b1);
      FMT_YUV: begin
        push_yuv(d[23:16], d[31:24], d[15:8], 1'b0);
        push_yuv(d[7:0], d[31:24], d[15:8], 1'b1);
      end
      default: ;  // unused format: no texel
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rgba_texel_t want;
    if (!rst_ni) begin
      settings.texel_format   = FMT_RGBA16;
      settings.palette_format = PAL_RGBA5551;
      settings.force_opaque   = 1'b0;
      settings.luma_gain      = LumaGainRst;
      settings.v_to_red       = VToRedRst;
      settings.u_to_green     = UToGreenRst;
      settings.v_to_green     = VToGreenRst;
      settings.u_to_blue      = UToBlueRst;
      texel_expect_q.delete();
      mismatch_count_o = 0;
      texels_checked_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (texel_expect_q.size() == 0) begin
          $display("%0t: unexpected texel, expected none, actual r%0d g%0d b%0d a%0d l%0d",
                   $time, red_i, green_i, blue_i, alpha_i, last_i);
          mismatch_count_o++;
        end else begin
          want = texel_expect_q.pop_front();
          check_field("red", want.red, red_i);
          check_field("green", want.green, green_i);
          check_field("blue", want.blue, blue_i);
          check_field("alpha", want.alpha, alpha_i);
          check_field("last", {7'b0, want.last}, {7'b0, last_i});
          texels_checked_o++;
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_TEXEL_FORMAT:   settings.texel_format   = cfg_data_i[3:0];
          REG_PALETTE_FORMAT: settings.palette_format = cfg_data_i[0];
          REG_FORCE_OPAQUE:   settings.force_opaque   = cfg_data_i[0];
          REG_LUMA_GAIN:      settings.luma_gain      = cfg_data_i;
          REG_V_TO_RED:       settings.v_to_red       = cfg_data_i;
          REG_U_TO_GREEN:     settings.u_to_green     = cfg_data_i;
          REG_V_TO_GREEN:     settings.v_to_green     = cfg_data_i;
          REG_U_TO_BLUE:      settings.u_to_blue      = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) predict_item(command_i, data_i, palette_index_i);
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Top of the texel decoder testbench: clock, reset, register writes and item
// stimulus with random idling. Depends on tfr_pkg, texel_checker and the DUT.
module testbench;
  import tfr_pkg::*;

  localparam int unsigned PalDepth     = 256;
  localparam int unsigned ClkPeriod    = 10;
  localparam int unsigned TimeoutNs    = 2_000_000;
  localparam int unsigned RandomItems  = 1050;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned HoldCycles   = 200;
  localparam int unsigned HoldAtItem   = 700;
  localparam int unsigned IdlePct      = 31;
  localparam logic [3:0]  FMT_UNUSED_LO = 4'd10;
  localparam logic [3:0]  FMT_UNUSED_HI = 4'd15;
  localparam logic [9:0]  CoefMax       = 10'd1023;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  cmd_e        command = CMD_CONVERT;
  logic [31:0] data = '0;
  logic [7:0]  palette_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  red, green, blue, alpha;
  logic        last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  int unsigned mismatches, texels_checked, texels_waiting;
  int unsigned items_sent = 0;
  int unsigned palette_writes = 0;
  int unsigned setting_count = 0;
  bit          calm = 1'b0;
  int unsigned stall_hold_left = 0;
  bit          stall_hold_done = 1'b0;

  always #(ClkPeriod / 2) clk = ~clk;

  texel_format_to_rgba8888 #(.PALETTE_DEPTH(PalDepth)) DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .command_i       (command),
    .data_i          (data),
    .palette_index_i (palette_index),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .red_o           (red),
    .green_o         (green),
    .blue_o          (blue),
    .alpha_o         (alpha),
    .last_o          (last),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  texel_checker #(.PAL_DEPTH(PalDepth)) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .command_i        (command),
    .data_i           (data),
    .palette_index_i  (palette_index),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .red_i            (red),
    .green_i          (green),
    .blue_i           (blue),
    .alpha_i          (alpha),
    .last_i           (last),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .texels_checked_o (texels_checked),
    .texels_waiting_o (texels_waiting)
  );

  // receiver: random stalls, one long hold-off to back up the pipeline
  always @(posedge clk) begin
    if (!stall_hold_done && items_sent >= HoldAtItem) begin
      stall_hold_done = 1'b1;
      stall_hold_left = HoldCycles;
    end
    if (stall_hold_left > 0) begin
      out_stall <= 1'b1;
      stall_hold_left--;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < IdlePct);
    end
  end

  initial begin
    #(TimeoutNs);
    $display("Timeout with %0d texels outstanding", texels_waiting);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic offer_item(cmd_e cmd, logic [31:0] d, logic [7:0] idx);
    while (!calm && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    command       <= cmd;
    data          <= d;
    palette_index <= idx;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (cmd == CMD_PAL_WRITE) palette_writes++;
  endtask

  // wait out all texels plus pipeline latency for items with no result
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (texels_waiting != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e r, logic [CfgDataW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic apply_settings(logic [3:0] fmt, pal_fmt_e pf, logic opaque,
                                logic [9:0] lg, logic [9:0] vr, logic [9:0] ug,
                                logic [9:0] vg, logic [9:0] ub);
    write_reg(REG_TEXEL_FORMAT, 10'(fmt));
    write_reg(REG_PALETTE_FORMAT, 10'(pf));
    write_reg(REG_FORCE_OPAQUE, 10'(opaque));
    write_reg(REG_LUMA_GAIN, lg);
    write_reg(REG_V_TO_RED, vr);
    write_reg(REG_U_TO_GREEN, ug);
    write_reg(REG_V_TO_GREEN, vg);
    write_reg(REG_U_TO_BLUE, ub);
    cfg_valid <= 1'b0;
    setting_count++;
  endtask

  initial begin
    int unsigned rand_items;
    int unsigned phase;
    int unsigned burst;
    logic [3:0]  fmt;
    logic        unused;
    logic [9:0]  lg, vr, ug, vg, ub;
    cmd_e        cmd;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every palette entry gets written before any lookup
    for (int e = 0; e < PalDepth; e++) offer_item(CMD_PAL_WRITE, $urandom, 8'(e));
    drain();

    // directed: field extremes in every format
    for (int f = FMT_RGBA16; f <= FMT_YUV; f++) begin
      apply_settings(4'(f), (f == FMT_CI4) ? PAL_IA16 : PAL_RGBA5551, f == FMT_CI4,
                     LumaGainRst, VToRedRst, UToGreenRst, VToGreenRst, UToBlueRst);
      offer_item(CMD_CONVERT, 32'h0000_0000, 8'h00);
      offer_item(CMD_CONVERT, 32'hFFFF_FFFF, 8'hFF);
      if (f == FMT_YUV) offer_item(CMD_CONVERT, 32'h8080_8010, 8'h00);
      drain();
    end
    apply_settings(FMT_UNUSED_HI, PAL_RGBA5551, 1'b0,
                   LumaGainRst, VToRedRst, UToGreenRst, VToGreenRst, UToBlueRst);
    offer_item(CMD_CONVERT, 32'hFFFF_FFFF, 8'h00);
    offer_item(CMD_CONVERT, 32'h0000_0000, 8'h00);
    drain();

    rand_items = 0;
    phase = 0;
    while (rand_items < RandomItems) begin
      unused = (phase % 7 == 6);
      fmt = unused ? 4'($urandom_range(FMT_UNUSED_HI, FMT_UNUSED_LO)) : 4'(phase % 10);
      case (phase % 4)
        0: begin lg = CoefMax; vr = CoefMax; ug = CoefMax; vg = CoefMax; ub = CoefMax; end
        1: begin lg = '0; vr = '0; ug = '0; vg = '0; ub = '0; end
        2: begin
          lg = LumaGainRst; vr = VToRedRst; ug = UToGreenRst;
          vg = VToGreenRst; ub = UToBlueRst;
        end
        default: begin
          lg = 10'($urandom); vr = 10'($urandom); ug = 10'($urandom);
          vg = 10'($urandom); ub = 10'($urandom);
        end
      endcase
      calm = (phase >= 9 && phase < 12);
      apply_settings(fmt, pal_fmt_e'($urandom_range(1)), 1'($urandom_range(1)),
                     lg, vr, ug, vg, ub);
      burst = unused ? 6 : $urandom_range(80, 40);
      repeat (burst) begin
        cmd = ($urandom_range(99) < 12) ? CMD_PAL_WRITE : CMD_CONVERT;
        offer_item(cmd, $urandom, 8'($urandom));
        if (!unused || cmd == CMD_PAL_WRITE) rand_items++;
      end
      drain();
      phase++;
    end
    calm = 1'b0;

    $display("Run covered %0d items (%0d palette writes) over %0d register settings,",
             items_sent, palette_writes, setting_count);
    $display("with %0d texels compared against prediction.", texels_checked);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
